// ===== sv/suk_pkg.sv =====
// ----------------------------------------------------------------------------
// suk_pkg
// Shared types and constants of the sorted unique key table.
// ----------------------------------------------------------------------------
package suk_pkg;

	localparam int DEPTH_DEF      = 16;
	localparam int KEY_BITS_DEF   = 16;
	localparam int FIELD_KEY_BITS = 16;
	localparam int PAYLOAD_BITS   = 16;
	localparam int POS_OUT_BITS   = 5;
	localparam int S_TDATA_BITS   = 32;
	localparam int S_TUSER_BITS   = 8;
	localparam int M_TDATA_BITS   = 40;
	localparam int M_TUSER_BITS   = 8;

	typedef enum logic [1:0] {
		CMD_INSERT = 2'd0,
		CMD_FIND   = 2'd1,
		CMD_DUMP   = 2'd2
	} cmd_t;

	typedef enum logic [2:0] {
		ST_INSERTED  = 3'd0,
		ST_DUPLICATE = 3'd1,
		ST_FULL      = 3'd2,
		ST_FOUND     = 3'd3,
		ST_NOT_FOUND = 3'd4,
		ST_DUMPED    = 3'd5
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_DUMP
	} state_t;

	typedef struct packed {
		logic                    ins;
		logic                    kind;
		logic [PAYLOAD_BITS-1:0] payload;
	} cell_cmd_t;

	typedef struct packed {
		logic occ;
		logic lt;
		logic eq;
		logic bnd;
	} cell_flags_t;

	typedef struct packed {
		status_t                   status;
		logic [POS_OUT_BITS-1:0]   position;
		logic [FIELD_KEY_BITS-1:0] entry_key;
		logic                      entry_kind;
		logic [PAYLOAD_BITS-1:0]   entry_payload;
		logic                      last;
	} res_t;

endpackage

// ===== sv/suk_cell.sv =====
// ----------------------------------------------------------------------------
// suk_cell
// One slot of the sorted chain: compares its key with the broadcast key and,
// on insert, keeps its entry, takes the new one, or takes its left neighbor's.
// ----------------------------------------------------------------------------
module suk_cell #(
	parameter int KEY_BITS = suk_pkg::KEY_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  suk_pkg::cell_cmd_t                  cmd,
	input  logic [KEY_BITS-1:0]                 cmd_key,
	input  logic                                prev_lt,
	input  logic                                prev_occ,
	input  logic [KEY_BITS-1:0]                 prev_key,
	input  logic                                prev_kind,
	input  logic [suk_pkg::PAYLOAD_BITS-1:0]    prev_payload,
	output suk_pkg::cell_flags_t                flags,
	output logic [KEY_BITS-1:0]                 key,
	output logic                                kind,
	output logic [suk_pkg::PAYLOAD_BITS-1:0]    payload
);
	import suk_pkg::*;

	logic                    occ_q;
	logic [KEY_BITS-1:0]     key_q;
	logic                    kind_q;
	logic [PAYLOAD_BITS-1:0] payload_q;
	logic                    lt;
	logic                    eq;
	logic                    shift_en;

	assign lt       = occ_q && (key_q < cmd_key);
	assign eq       = occ_q && (key_q == cmd_key);
	assign shift_en = cmd.ins && !lt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= 1'b0;
		end else if (shift_en) begin
			occ_q <= prev_lt ? 1'b1 : prev_occ;
		end
	end

	always_ff @(posedge clk) begin
		if (shift_en) begin
			if (prev_lt) begin
				key_q     <= cmd_key;
				kind_q    <= cmd.kind;
				payload_q <= cmd.payload;
			end else begin
				key_q     <= prev_key;
				kind_q    <= prev_kind;
				payload_q <= prev_payload;
			end
		end
	end

	assign flags.occ = occ_q;
	assign flags.lt  = lt;
	assign flags.eq  = eq;
	assign flags.bnd = !lt && prev_lt;
	assign key       = key_q;
	assign kind      = kind_q;
	assign payload   = payload_q;

endmodule

// ===== sv/sorted_unique_key_table_top.sv =====
// ----------------------------------------------------------------------------
// sorted_unique_key_table_top
// Sorted table of unique keys held in a chain of compare-and-shift cells.
// ----------------------------------------------------------------------------
// Insert and find: the beat is taken, then every cell compares the key in the
// same cycle and the chain shifts right of the insertion slot. A dump takes
// the beat, then returns one stored entry per cycle while the output register
// is free; an empty dump and an unused command leave the sequencer idle. The
// input is taken whenever the sequencer is idle, even while a result still
// sits in the output register; a full output register holds the sequencer.
module sorted_unique_key_table_top #(
	parameter int DEPTH    = suk_pkg::DEPTH_DEF,
	parameter int KEY_BITS = suk_pkg::KEY_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [suk_pkg::S_TDATA_BITS-1:0]  s_tdata,  // key, payload
	input  logic [suk_pkg::S_TUSER_BITS-1:0]  s_tuser,  // command, kind
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [suk_pkg::M_TDATA_BITS-1:0]  m_tdata,  // position, entry_key, entry_payload
	output logic [suk_pkg::M_TUSER_BITS-1:0]  m_tuser,  // status, entry_kind
	output logic                              m_tlast
);
	import suk_pkg::*;

	localparam int POS_W = $clog2(DEPTH + 1);
	localparam int IDX_W = $clog2(DEPTH);

	state_t                  state_q;
	state_t                  state_d;
	cmd_t                    cmd_q;
	logic [KEY_BITS-1:0]     key_q;
	logic                    kind_q;
	logic [PAYLOAD_BITS-1:0] payload_q;
	logic [POS_W-1:0]        count_q;
	logic [IDX_W-1:0]        dump_idx_q;
	logic                    m_tvalid_q;
	res_t                    res_q;
	res_t                    res_d;

	logic                    out_free;
	logic                    accept;
	logic                    exec_fire;
	logic                    dump_fire;
	logic                    ins_go;
	logic                    dup;
	logic                    full;
	logic                    last_dump;
	cmd_t                    in_cmd;

	cell_cmd_t               ccmd;
	cell_flags_t             flags  [DEPTH];
	logic [KEY_BITS-1:0]     c_key  [DEPTH];
	logic                    c_kind [DEPTH];
	logic [PAYLOAD_BITS-1:0] c_pay  [DEPTH];
	logic [DEPTH-1:0]        eq_vec;
	logic [DEPTH-1:0]        occ_vec;
	logic [DEPTH-1:0]        rd_sel;
	logic [POS_W-1:0]        eq_pos;
	logic [POS_W-1:0]        bnd_pos;
	logic [KEY_BITS-1:0]     rd_key;
	logic                    rd_kind;
	logic [PAYLOAD_BITS-1:0] rd_pay;

	assign in_cmd    = cmd_t'(s_tuser[1:0]);
	assign out_free  = !m_tvalid_q || m_tready;
	assign full      = (count_q == POS_W'(DEPTH));
	assign dup       = |eq_vec;
	assign last_dump = (POS_W'(dump_idx_q) == count_q - POS_W'(1));

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					unique case (in_cmd)
						CMD_INSERT, CMD_FIND: state_d = S_EXEC;
						CMD_DUMP:             state_d = (count_q == '0) ? S_IDLE : S_DUMP;
						default:              state_d = S_IDLE;
					endcase
				end
			end
			S_EXEC: begin
				if (out_free) state_d = S_IDLE;
			end
			S_DUMP: begin
				if (out_free && last_dump) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		s_tready  = (state_q == S_IDLE);
		accept    = s_tready && s_tvalid;
		exec_fire = (state_q == S_EXEC) && out_free;
		dump_fire = (state_q == S_DUMP) && out_free;
		ins_go    = exec_fire && (cmd_q == CMD_INSERT) && !dup && !full;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			count_q    <= '0;
			dump_idx_q <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ins_go) count_q <= count_q + POS_W'(1);
			if (accept) dump_idx_q <= '0;
			else if (dump_fire) dump_idx_q <= dump_idx_q + IDX_W'(1);
			if (exec_fire || dump_fire) m_tvalid_q <= 1'b1;
			else if (m_tready) m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q     <= in_cmd;
			key_q     <= KEY_BITS'(s_tdata[FIELD_KEY_BITS-1:0]);
			kind_q    <= s_tuser[2];
			payload_q <= s_tdata[FIELD_KEY_BITS +: PAYLOAD_BITS];
		end
		if (exec_fire || dump_fire) res_q <= res_d;
	end

	assign ccmd.ins     = ins_go;
	assign ccmd.kind    = kind_q;
	assign ccmd.payload = payload_q;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic                    p_lt;
		logic                    p_occ;
		logic [KEY_BITS-1:0]     p_key;
		logic                    p_kind;
		logic [PAYLOAD_BITS-1:0] p_pay;

		if (i == 0) begin : g_head
			assign p_lt   = 1'b1;
			assign p_occ  = 1'b0;
			assign p_key  = '0;
			assign p_kind = 1'b0;
			assign p_pay  = '0;
		end else begin : g_link
			assign p_lt   = flags[i-1].lt;
			assign p_occ  = flags[i-1].occ;
			assign p_key  = c_key[i-1];
			assign p_kind = c_kind[i-1];
			assign p_pay  = c_pay[i-1];
		end

		suk_cell #(
			.KEY_BITS(KEY_BITS)
		) u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.cmd         (ccmd),
			.cmd_key     (key_q),
			.prev_lt     (p_lt),
			.prev_occ    (p_occ),
			.prev_key    (p_key),
			.prev_kind   (p_kind),
			.prev_payload(p_pay),
			.flags       (flags[i]),
			.key         (c_key[i]),
			.kind        (c_kind[i]),
			.payload     (c_pay[i])
		);

		assign eq_vec[i]  = flags[i].eq;
		assign occ_vec[i] = flags[i].occ;
		assign rd_sel[i]  = (state_q == S_DUMP) ? (dump_idx_q == IDX_W'(i)) : flags[i].eq;
	end

	always_comb begin
		eq_pos  = '0;
		bnd_pos = '0;
		rd_key  = '0;
		rd_kind = 1'b0;
		rd_pay  = '0;
		for (int i = 0; i < DEPTH; i++) begin
			if (flags[i].eq)  eq_pos  |= POS_W'(i);
			if (flags[i].bnd) bnd_pos |= POS_W'(i);
			if (rd_sel[i]) begin
				rd_key  |= c_key[i];
				rd_kind |= c_kind[i];
				rd_pay  |= c_pay[i];
			end
		end
	end

	always_comb begin
		res_d               = '0;
		res_d.last          = 1'b1;
		res_d.position      = POS_OUT_BITS'(count_q);
		res_d.entry_key     = FIELD_KEY_BITS'(rd_key);
		res_d.entry_kind    = rd_kind;
		res_d.entry_payload = rd_pay;
		if (state_q == S_DUMP) begin
			res_d.status   = ST_DUMPED;
			res_d.position = POS_OUT_BITS'(dump_idx_q);
			res_d.last     = last_dump;
		end else if (dup) begin
			res_d.status   = (cmd_q == CMD_INSERT) ? ST_DUPLICATE : ST_FOUND;
			res_d.position = POS_OUT_BITS'(eq_pos);
		end else begin
			res_d.entry_key     = '0;
			res_d.entry_kind    = 1'b0;
			res_d.entry_payload = '0;
			if (cmd_q != CMD_INSERT) begin
				res_d.status = ST_NOT_FOUND;
			end else if (full) begin
				res_d.status = ST_FULL;
			end else begin
				res_d.status        = ST_INSERTED;
				res_d.position      = POS_OUT_BITS'(bnd_pos);
				res_d.entry_key     = FIELD_KEY_BITS'(key_q);
				res_d.entry_kind    = kind_q;
				res_d.entry_payload = payload_q;
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tlast  = res_q.last;
	assign m_tdata  = {3'b000, res_q.entry_payload, res_q.entry_key, res_q.position};
	assign m_tuser  = {4'b0000, res_q.entry_kind, res_q.status};

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= POS_W'(DEPTH))
		else $error("entry count beyond depth");

	a_occ_count: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(occ_vec) == int'(count_q))
		else $error("occupied cells disagree with entry count");

	a_unique_keys: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(eq_vec))
		else $error("key matches more than one cell");

	a_insert_count: assert property (@(posedge clk) disable iff (!arst_n)
		ins_go |=> count_q == $past(count_q) + POS_W'(1))
		else $error("insert did not advance entry count");

endmodule
